// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the polygon centroid RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the centroid block.
package pc_pkg;

  localparam int COORD_BITS       = 16;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int AREA_BITS        = 40;
  localparam int MOMENT_BITS      = 56;
  localparam int DEN_BITS         = AREA_BITS + 2;
  localparam int PROD_BITS        = 2 * COORD_BITS;
  localparam int CROSS_BITS       = PROD_BITS + 1;
  localparam int SUM_BITS         = COORD_BITS + 1;
  localparam int TERM_BITS        = SUM_BITS + CROSS_BITS;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_ZERO_AREA = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;        // vertex transfer: latch vertex, set up its edge
    logic    load_close;  // set up the closing edge back to the first vertex
    logic    term_en;     // cross and moment terms are being registered
    logic    start_x;     // start dividing the x moment
    logic    start_y;     // start dividing the y moment
    logic    take_x;      // capture the x quotient
    logic    take_y;      // capture the y quotient
    logic    write;       // load the output register and clear the sums
    status_t status;      // status of the result being written
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;   // no vertex received yet in this polygon
    logic cnt_full;   // MAX_VERTICES or more vertices received
    logic area_zero;  // doubled area sums to zero
    logic div_done;   // divider finished this cycle
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

// ===== hdl/polygon_centroid.sv =====
// Polygon centroid by the shoelace formula: top level joining controller and datapath.
// Vertex transfers: the first vertex and vertices past the limit leave the controller idle;
// every other vertex drops ready while it passes the two multiply stages (S_MUL, S_CROSS).
// After the last vertex, a valid result waits on two 56-step divisions, x and then y.
// Zero-area and overflow polygons finish without dividing.
// rst is synchronous, active high; it clears the sums, count, controller and output valid.
module polygon_centroid #(
  parameter int MAX_VERTICES = pc_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [2*pc_pkg::COORD_BITS-1:0]    s_axis_tdata,  // vertex_x, vertex_y
  input  logic                               s_axis_tlast,  // last_vertex
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [2*pc_pkg::COORD_BITS-1:0]    m_axis_tdata,  // centroid_x, centroid_y
  output logic [1:0]                         m_axis_tuser   // status
);

  localparam int CW = pc_pkg::COORD_BITS;

  pc_pkg::dp_cmd_t      cmd;
  pc_pkg::dp_sts_t      sts;
  logic signed [CW-1:0] centroid_x, centroid_y;
  pc_pkg::status_t      status;

  pc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_x       (s_axis_tdata[CW-1:0]),
    .in_y       (s_axis_tdata[2*CW-1:CW]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_x      (centroid_x),
    .out_y      (centroid_y),
    .out_status (status)
  );

  // Pack the result transfer.
  assign m_axis_tdata = {centroid_y, centroid_x};
  assign m_axis_tuser = status;

endmodule

// ===== hdl/pc_div.sv =====
// Restoring divider, one quotient bit per cycle, with saturation to the coordinate range.
module pc_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [pc_pkg::MOMENT_BITS-1:0]  dividend,
  input  logic signed [pc_pkg::DEN_BITS-1:0]     divisor,
  output logic                                   busy,
  output logic                                   done,
  output logic signed [pc_pkg::COORD_BITS-1:0]   quotient
);

  `include "assert_macros.svh"

  localparam int MW     = pc_pkg::MOMENT_BITS;
  localparam int DW     = pc_pkg::DEN_BITS;
  localparam int CW     = pc_pkg::COORD_BITS;
  localparam int STEP_W = $clog2(MW);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MW - 1);
  localparam logic [MW-1:0] POS_LIM = {{(MW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [MW-1:0] NEG_LIM = {{(MW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

  logic [MW-1:0]     quo;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dsr;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic [DW:0]       shifted;
  logic [DW:0]       diff;
  logic              fits;
  logic [MW-1:0]     quo_neg;

  // One trial subtraction per cycle.
  assign shifted = {rem, quo[MW-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = (shifted >= {1'b0, dsr});

  // Step counter and handshake with the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Magnitudes are divided; the sign is applied at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[MW-1] ? $unsigned(-dividend) : $unsigned(dividend);
      dsr <= divisor[DW-1] ? $unsigned(-divisor) : $unsigned(divisor);
      neg <= dividend[MW-1] ^ divisor[DW-1];
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[MW-2:0], fits};
    end
  end

  // Truncated quotient, saturated to the signed coordinate range.
  assign quo_neg = '0 - quo;

  always_comb begin
    if (neg) begin
      if (quo > NEG_LIM) quotient = {1'b1, {(CW-1){1'b0}}};
      else               quotient = quo_neg[CW-1:0];
    end else begin
      if (quo > POS_LIM) quotient = {1'b0, {(CW-1){1'b1}}};
      else               quotient = quo[CW-1:0];
    end
  end

  `PC_ASSERT_IMP(a_div_no_restart, start, !busy, "divider started while busy")
  `PC_ASSERT_NXT(a_div_done_pulse, done, !done && !busy, "divider done is not a single pulse")

endmodule

// ===== hdl/pc_dp.sv =====
// Datapath: vertex registers, shoelace multiply-accumulate, divider and output register.
module pc_dp #(
  parameter int MAX_VERTICES = pc_pkg::MAX_VERTICES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [pc_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [pc_pkg::COORD_BITS-1:0] in_y,
  input  pc_pkg::dp_cmd_t                      cmd,
  output pc_pkg::dp_sts_t                      sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pc_pkg::COORD_BITS-1:0] out_x,
  output logic signed [pc_pkg::COORD_BITS-1:0] out_y,
  output pc_pkg::status_t                      out_status
);

  `include "assert_macros.svh"

  localparam int CW    = pc_pkg::COORD_BITS;
  localparam int CNT_W = $clog2(MAX_VERTICES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  logic signed [CW-1:0]                  first_x, first_y, prev_x, prev_y;
  logic [CNT_W-1:0]                      vertex_count;
  logic signed [CW-1:0]                  e_x0, e_y0, e_x1, e_y1;
  logic signed [pc_pkg::PROD_BITS-1:0]   p_xy, p_yx;
  logic signed [pc_pkg::SUM_BITS-1:0]    sum_x, sum_y;
  logic signed [pc_pkg::CROSS_BITS-1:0]  cross_c, cross_r;
  logic signed [pc_pkg::TERM_BITS-1:0]   term_x, term_y;
  logic                                  acc_pend;
  logic signed [pc_pkg::AREA_BITS-1:0]   area_sum;
  logic signed [pc_pkg::MOMENT_BITS-1:0] moment_x_sum, moment_y_sum;
  logic signed [pc_pkg::DEN_BITS-1:0]    den;
  logic signed [pc_pkg::MOMENT_BITS-1:0] div_dividend;
  logic signed [CW-1:0]                  div_q, qx, qy;
  logic                                  div_busy, div_done;

  // Vertex count saturates one past the limit to mark overflow.
  always_ff @(posedge clk) begin
    if (rst || cmd.write) begin
      vertex_count <= '0;
    end else if (cmd.load && vertex_count <= CNT_MAX) begin
      vertex_count <= vertex_count + 1'b1;
    end
  end

  // First and previous vertex.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_x <= in_x;
      prev_y <= in_y;
      if (vertex_count == '0) begin
        first_x <= in_x;
        first_y <= in_y;
      end
    end
  end

  // Edge end points: previous to current, or current back to first.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_x0 <= prev_x;
      e_y0 <= prev_y;
      e_x1 <= in_x;
      e_y1 <= in_y;
    end else if (cmd.load_close) begin
      e_x0 <= prev_x;
      e_y0 <= prev_y;
      e_x1 <= first_x;
      e_y1 <= first_y;
    end
  end

  // Stage one: the two cross products and the coordinate sums.
  always_ff @(posedge clk) begin
    p_xy  <= e_x0 * e_y1;
    p_yx  <= e_x1 * e_y0;
    sum_x <= pc_pkg::SUM_BITS'(e_x0) + pc_pkg::SUM_BITS'(e_x1);
    sum_y <= pc_pkg::SUM_BITS'(e_y0) + pc_pkg::SUM_BITS'(e_y1);
  end

  // Stage two: cross term and the two moment terms.
  assign cross_c = pc_pkg::CROSS_BITS'(p_xy) - pc_pkg::CROSS_BITS'(p_yx);

  always_ff @(posedge clk) begin
    cross_r <= cross_c;
    term_x  <= sum_x * cross_c;
    term_y  <= sum_y * cross_c;
  end

  // Accumulate in the cycle after the terms are registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
    end else begin
      acc_pend <= cmd.term_en;
    end
  end

  // Wrapping shoelace sums, cleared after every polygon.
  always_ff @(posedge clk) begin
    if (rst || cmd.write) begin
      area_sum     <= '0;
      moment_x_sum <= '0;
      moment_y_sum <= '0;
    end else if (acc_pend) begin
      area_sum     <= area_sum + pc_pkg::AREA_BITS'(cross_r);
      moment_x_sum <= moment_x_sum + pc_pkg::MOMENT_BITS'(term_x);
      moment_y_sum <= moment_y_sum + pc_pkg::MOMENT_BITS'(term_y);
    end
  end

  // Divisor is three times the doubled area.
  always_ff @(posedge clk) begin
    den <= pc_pkg::DEN_BITS'(area_sum) + (pc_pkg::DEN_BITS'(area_sum) <<< 1);
  end

  // One divider serves both coordinates in turn.
  assign div_dividend = cmd.start_y ? moment_y_sum : moment_x_sum;

  pc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_x || cmd.start_y),
    .dividend (div_dividend),
    .divisor  (den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_x) qx <= div_q;
    if (cmd.take_y) qy <= div_q;
  end

  // Output register; a new result may load as the old one transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_status <= cmd.status;
      if (cmd.status == pc_pkg::ST_VALID) begin
        out_x <= qx;
        out_y <= qy;
      end else begin
        out_x <= '0;
        out_y <= '0;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.cnt_zero  = (vertex_count == '0);
    sts.cnt_full  = (vertex_count >= CNT_MAX);
    sts.area_zero = (area_sum == '0);
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || out_ready;
  end

  `PC_ASSERT_IMP(a_dp_acc_no_clear, acc_pend, !cmd.write && !div_busy, "accumulate overlap")

endmodule

// ===== hdl/pc_ctrl.sv =====
// Controller state machine sequencing edges, the closing edge, division and result write.
module pc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  pc_pkg::dp_sts_t sts,
  output pc_pkg::dp_cmd_t cmd
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CROSS,
    S_SETTLE,
    S_CHECK,
    S_STARTX,
    S_WAITX,
    S_STARTY,
    S_WAITY,
    S_WRITE
  } state_t;

  state_t          state;
  logic            close_pend;
  logic            last_r;
  pc_pkg::status_t status_r;
  logic            accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // State and registered flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      close_pend <= 1'b0;
      last_r     <= 1'b0;
      status_r   <= pc_pkg::ST_VALID;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_r     <= in_last;
            close_pend <= in_last;
            if (in_last && sts.cnt_full) begin
              status_r <= pc_pkg::ST_OVERFLOW;
              state    <= S_WRITE;
            end else if (!sts.cnt_zero && !sts.cnt_full) begin
              state <= S_MUL;
            end else if (in_last) begin
              // A lone vertex has no area; the sums are still clear.
              state <= S_CHECK;
            end
          end
        end
        S_MUL: begin
          state <= S_CROSS;
        end
        S_CROSS: begin
          if (close_pend) begin
            close_pend <= 1'b0;
            state      <= S_MUL;
          end else if (last_r) begin
            state <= S_SETTLE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SETTLE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (sts.area_zero) begin
            status_r <= pc_pkg::ST_ZERO_AREA;
            state    <= S_WRITE;
          end else begin
            status_r <= pc_pkg::ST_VALID;
            state    <= S_STARTX;
          end
        end
        S_STARTX: begin
          state <= S_WAITX;
        end
        S_WAITX: begin
          if (sts.div_done) state <= S_STARTY;
        end
        S_STARTY: begin
          state <= S_WAITY;
        end
        S_WAITY: begin
          if (sts.div_done) state <= S_WRITE;
        end
        S_WRITE: begin
          if (sts.out_free) begin
            last_r <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd            = '0;
    cmd.status     = status_r;
    cmd.load       = accept;
    cmd.term_en    = (state == S_CROSS);
    cmd.load_close = (state == S_CROSS) && close_pend;
    cmd.start_x    = (state == S_STARTX);
    cmd.start_y    = (state == S_STARTY);
    cmd.take_x     = (state == S_WAITX) && sts.div_done;
    cmd.take_y     = (state == S_WAITY) && sts.div_done;
    cmd.write      = (state == S_WRITE) && sts.out_free;
  end

  `PC_ASSERT_IMP(a_ctrl_div_nonzero, cmd.start_x || cmd.start_y, !sts.area_zero, "zero divisor")
  `PC_ASSERT_NXT(a_ctrl_hold_after_last, accept && in_last, !in_ready, "vertex taken too early")

endmodule
